FILE: design/ctf_pkg.sv
// Shared types, codes and the byte-wise CRC-32 function for the CRC-32 trailer framer.
// Used by ctf_burst and crc32_trailer_framer; depends on nothing else.
package ctf_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int TRAILER_BYTES = 4;
   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   // First position and position of the final trailer byte in a five-transfer burst.
   localparam logic [2:0] POS_FIRST = 3'd0;
   localparam logic [2:0] POS_LAST = 3'(TRAILER_BYTES);

   localparam logic [1:0] CSR_VERSION = 2'd0;
   localparam logic [1:0] CSR_MAX_PACKET = 2'd1;

   localparam logic [1:0] VER_UNSUPPORTED = 2'd0;
   localparam logic [1:0] VER_CRC = 2'd3;

   localparam logic ACT_PROTECT = 1'b0;
   localparam logic ACT_VALIDATE = 1'b1;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NO_ROOM = 3'd1;
   localparam logic [2:0] ST_TOO_SHORT = 3'd2;
   localparam logic [2:0] ST_MISMATCH = 3'd3;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

   // One burst of results caused by one input byte: a single result, or an
   // echoed byte followed by four trailer bytes.
   typedef struct packed {
      logic [7:0]  first_byte;
      logic        first_last;
      logic [2:0]  first_status;
      logic [15:0] length;
      logic        trailer;
      logic [31:0] crc;
   } ctf_burst_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] sat16(input logic [LENGTH_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000FFFF) ? 16'hFFFF : w[15:0];
   endfunction

endpackage

FILE: design/ctf_burst.sv
// Result register of the framer: holds one burst and hands it out one transfer a cycle
// while rsp_ready is high. Depends on ctf_pkg.
module ctf_burst (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ctf_pkg::ctf_burst_type load_burst,
   output logic                   space,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last,
   output logic [2:0]             rsp_status,
   output logic [15:0]            rsp_body_length
);
   import ctf_pkg::*;

   logic          valid_ff, valid_in;
   logic [2:0]    pos_ff, pos_in;
   ctf_burst_type burst_ff, burst_in;
   logic          at_final;

   assign at_final = burst_ff.trailer ? (pos_ff == POS_LAST) : (pos_ff == POS_FIRST);
   assign space = !valid_ff || (rsp_ready && at_final);
   assign rsp_valid = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      pos_in = pos_ff;
      burst_in = burst_ff;
      if (valid_ff && rsp_ready) begin
         if (at_final) begin
            valid_in = 1'b0;
            pos_in = POS_FIRST;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
      if (load) begin
         valid_in = 1'b1;
         pos_in = POS_FIRST;
         burst_in = load_burst;
      end
   end

   always_comb begin
      rsp_out_byte = 8'd0;
      rsp_out_last = 1'b0;
      rsp_status = ST_OK;
      rsp_body_length = 16'd0;
      case (pos_ff)
         3'd0: begin
            rsp_out_byte = burst_ff.first_byte;
            rsp_out_last = burst_ff.first_last;
            rsp_status = burst_ff.first_status;
            rsp_body_length = burst_ff.trailer ? 16'd0 : burst_ff.length;
         end
         3'd1: rsp_out_byte = burst_ff.crc[31:24];
         3'd2: rsp_out_byte = burst_ff.crc[23:16];
         3'd3: rsp_out_byte = burst_ff.crc[15:8];
         3'd4: begin
            rsp_out_byte = burst_ff.crc[7:0];
            rsp_out_last = 1'b1;
            rsp_body_length = burst_ff.length;
         end
         default: rsp_out_byte = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff <= POS_FIRST;
      end else begin
         valid_ff <= valid_in;
         pos_ff <= pos_in;
      end
      burst_ff <= burst_in;
   end

   // A new burst may only land when the previous one is gone or finishing.
   a_load_space: assert property (@(posedge clock) disable iff (reset)
      load |-> space)
      else $error("burst loaded while result register busy");

   // A burst without a trailer is a single transfer.
   a_single_pos: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !burst_ff.trailer |-> pos_ff == POS_FIRST)
      else $error("single result advanced past its first position");

   // A trailer burst marks only its final transfer as last.
   a_trailer_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && burst_ff.trailer && pos_ff != POS_LAST |-> !rsp_out_last)
      else $error("trailer burst flagged last early");

   // Each transfer inside a burst steps to the next position.
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ready && !at_final |=> pos_ff == $past(pos_ff) + 3'd1)
      else $error("burst position did not advance");

endmodule

FILE: design/crc32_trailer_framer.sv
// Top level of the CRC-32 trailer framer: packet state, CRC update and register port.
// Depends on ctf_pkg and ctf_burst.
//
// The framer takes one packet byte per cycle while results are taken and
// updates its reflected CRC-32 (polynomial 0xEDB88320, init all ones, final
// inversion) with a byte-wide update in the same cycle the byte is transferred.
// Each input byte causes zero or one result, except the last byte of a protected
// packet under version 3 when the trailer fits, which causes five: the echoed
// byte and then the CRC, most significant byte first. Results leave through a
// single result register; a new byte is taken while the previous burst is empty
// or is handing out its final transfer, and a packet with a trailer holds off the
// next byte while its trailer goes out. Validate consumes bytes silently and
// gives one status result at the last byte, under version 3 comparing the final
// four bytes against the CRC of the body before them. The two registers may be
// written at any time between packets and take effect on the next byte.
module crc32_trailer_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_body_length,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import ctf_pkg::*;

   logic [1:0]             version_ff;
   logic [15:0]            max_packet_ff;
   logic [31:0]            crc_ff, crc_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [31:0]            tail_ff, tail_in;

   logic                   accept;
   logic                   emit;
   logic                   clear;
   logic                   cnt_sat;
   logic [LENGTH_BITS-1:0] cnt_next;
   logic [31:0]            crc_prot;
   logic [31:0]            crc_val;
   logic                   no_room;
   ctf_burst_type          burst;
   logic                   space;

   assign accept = req_valid && req_ready;
   assign req_ready = space;

   assign cnt_sat = (count_ff == COUNT_MAX);
   assign cnt_next = cnt_sat ? COUNT_MAX : count_ff + LENGTH_BITS'(1);
   assign crc_prot = crc_byte(crc_ff, req_data_byte);
   assign crc_val = crc_byte(crc_ff, tail_ff[31:24]);
   assign no_room = cnt_sat ||
                    ((32'(cnt_next) + 32'(TRAILER_BYTES)) > 32'(max_packet_ff));

   always_comb begin
      emit = 1'b0;
      clear = 1'b0;
      crc_in = crc_ff;
      tail_in = tail_ff;
      burst.first_byte = 8'd0;
      burst.first_last = 1'b0;
      burst.first_status = ST_OK;
      burst.length = 16'd0;
      burst.trailer = 1'b0;
      burst.crc = ~crc_prot;

      if (version_ff == VER_UNSUPPORTED) begin
         if (req_last) begin
            emit = 1'b1;
            clear = 1'b1;
            burst.first_last = 1'b1;
            burst.first_status = ST_UNSUPPORTED;
            burst.length = sat16(cnt_next);
         end
      end else if (req_action == ACT_PROTECT) begin
         if (version_ff == VER_CRC) begin
            crc_in = crc_prot;
         end
         emit = 1'b1;
         burst.first_byte = req_data_byte;
         if (req_last) begin
            clear = 1'b1;
            burst.length = sat16(cnt_next);
            if (version_ff != VER_CRC) begin
               burst.first_last = 1'b1;
            end else if (no_room) begin
               burst.first_last = 1'b1;
               burst.first_status = ST_NO_ROOM;
            end else begin
               burst.trailer = 1'b1;
            end
         end
      end else begin
         if (version_ff == VER_CRC) begin
            if (count_ff >= LENGTH_BITS'(TRAILER_BYTES)) begin
               crc_in = crc_val;
            end
            tail_in = {tail_ff[23:0], req_data_byte};
         end
         if (req_last) begin
            emit = 1'b1;
            clear = 1'b1;
            burst.first_last = 1'b1;
            if (version_ff != VER_CRC) begin
               burst.length = sat16(cnt_next);
            end else if (cnt_next < LENGTH_BITS'(TRAILER_BYTES)) begin
               burst.first_status = ST_TOO_SHORT;
            end else begin
               // crc_in now holds the body CRC; tail_in is the trailer.
               burst.first_status = (~crc_in == tail_in) ? ST_OK : ST_MISMATCH;
               burst.length = sat16(cnt_next - LENGTH_BITS'(TRAILER_BYTES));
            end
         end
      end

      count_in = cnt_next;
      if (clear) begin
         crc_in = CRC_INIT;
         count_in = '0;
         tail_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VER_UNSUPPORTED;
         max_packet_ff <= 16'd4096;
         crc_ff <= CRC_INIT;
         count_ff <= '0;
         tail_ff <= 32'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_VERSION: version_ff <= csr_wdata[1:0];
               CSR_MAX_PACKET: max_packet_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            crc_ff <= crc_in;
            count_ff <= count_in;
            tail_ff <= tail_in;
         end
      end
   end

   ctf_burst u_burst (
      .clock           (clock),
      .reset           (reset),
      .load            (accept && emit),
      .load_burst      (burst),
      .space           (space),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_last    (rsp_out_last),
      .rsp_status      (rsp_status),
      .rsp_body_length (rsp_body_length)
   );

   // A transfer of a last byte always leaves the packet state cleared.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_last |=> count_ff == '0 && crc_ff == CRC_INIT && tail_ff == 32'd0)
      else $error("packet state not cleared after last byte");

   // The byte counter moves only on an input transfer.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("byte count changed without a transfer");

   // Under version 0 the CRC either holds its value or returns to its initial value.
   a_unsup_crc: assert property (@(posedge clock) disable iff (reset)
      accept && version_ff == VER_UNSUPPORTED |=> crc_ff == $past(crc_ff) ||
      crc_ff == CRC_INIT)
      else $error("CRC changed under unsupported version");

endmodule

FILE: bench/crc32_trailer_framer_tb.sv
// Self-checking testbench for crc32_trailer_framer: directed cases, then random packets.
// Depends on ctf_pkg for codes and widths and on the crc32_trailer_framer RTL.
module crc32_trailer_framer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ctf_pkg::*;

   localparam logic [1:0] VER_PLAIN_1 = 2'd1;
   localparam logic [1:0] VER_PLAIN_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 20;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 240;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_last;
      logic [2:0]  status;
      logic [15:0] body_length;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_body_length;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'd0;

   // Predicted block state and register copies.
   logic [1:0]  cfg_version = VER_UNSUPPORTED;
   logic [15:0] cfg_max_packet = 16'd4096;
   logic [31:0] run_crc = CRC_INIT;
   logic [15:0] seen_count = 16'd0;
   logic [31:0] tail_window = 32'd0;

   frame_result_type pending[$];
   logic [7:0]       pkt_bytes[$];
   logic             gaps_on = 1'b1;
   int               rsp_hold_cycles = 0;
   int               mismatches = 0;
   int               items_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   crc32_trailer_framer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_data_byte  (req_data_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .rsp_status     (rsp_status),
      .rsp_body_length(rsp_body_length),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Bit-serial form of the reflected CRC-32 byte update.
   function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      logic        fb;
      c = acc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

   function automatic void add_result(input logic [7:0] b, input logic l, input logic [2:0] st,
                                      input logic [15:0] len);
      pending.push_back('{out_byte: b, out_last: l, status: st, body_length: len});
   endfunction

   function automatic void restart_packet();
      run_crc = CRC_INIT;
      seen_count = 16'd0;
      tail_window = 32'd0;
   endfunction

   function automatic void predict_byte(input logic act, input logic [7:0] b, input logic lst);
      logic [15:0] prior;
      logic        at_max;
      logic [31:0] sig;
      prior = seen_count;
      at_max = (prior == COUNT_MAX);
      if (!at_max) seen_count = prior + 16'd1;
      if (cfg_version == VER_UNSUPPORTED) begin
         if (lst) begin
            add_result(8'd0, 1'b1, ST_UNSUPPORTED, seen_count);
            restart_packet();
         end
         return;
      end
      if (act == ACT_PROTECT) begin
         if (cfg_version == VER_CRC) run_crc = crc32_step(run_crc, b);
         if (!lst) begin
            add_result(b, 1'b0, ST_OK, 16'd0);
         end else if (cfg_version != VER_CRC) begin
            add_result(b, 1'b1, ST_OK, seen_count);
         end else if (at_max ||
                      ({1'b0, seen_count} + 17'(TRAILER_BYTES) > {1'b0, cfg_max_packet})) begin
            add_result(b, 1'b1, ST_NO_ROOM, seen_count);
         end else begin
            sig = ~run_crc;
            add_result(b, 1'b0, ST_OK, 16'd0);
            add_result(sig[31:24], 1'b0, ST_OK, 16'd0);
            add_result(sig[23:16], 1'b0, ST_OK, 16'd0);
            add_result(sig[15:8], 1'b0, ST_OK, 16'd0);
            add_result(sig[7:0], 1'b1, ST_OK, seen_count);
         end
      end else begin
         // The CRC sees a validated byte only once four newer bytes have pushed it out.
         if (cfg_version == VER_CRC) begin
            if (prior >= TRAILER_BYTES) run_crc = crc32_step(run_crc, tail_window[31:24]);
            tail_window = {tail_window[23:0], b};
         end
         if (lst) begin
            if (cfg_version != VER_CRC) begin
               add_result(8'd0, 1'b1, ST_OK, seen_count);
            end else if (seen_count < TRAILER_BYTES) begin
               add_result(8'd0, 1'b1, ST_TOO_SHORT, 16'd0);
            end else begin
               add_result(8'd0, 1'b1, (~run_crc == tail_window) ? ST_OK : ST_MISMATCH,
                          16'(seen_count - TRAILER_BYTES));
            end
         end
      end
      if (lst) restart_packet();
   endfunction

   function automatic void make_body(input int n);
      pkt_bytes.delete();
      repeat (n) pkt_bytes.push_back(8'($urandom));
   endfunction

   function automatic void append_trailer();
      logic [31:0] sig;
      sig = CRC_INIT;
      foreach (pkt_bytes[i]) sig = crc32_step(sig, pkt_bytes[i]);
      sig = ~sig;
      pkt_bytes.push_back(sig[31:24]);
      pkt_bytes.push_back(sig[23:16]);
      pkt_bytes.push_back(sig[15:8]);
      pkt_bytes.push_back(sig[7:0]);
   endfunction

   task automatic send_byte(input logic act, input logic [7:0] b, input logic lst);
      int gap;
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_data_byte <= b;
      req_last <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(act, b, lst);
      items_sent++;
   endtask

   task automatic send_packet(input logic act);
      foreach (pkt_bytes[i]) send_byte(act, pkt_bytes[i], i == pkt_bytes.size() - 1);
   endtask

   // Leaves the block idle: no expectation outstanding and no byte still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_VERSION: cfg_version = val[1:0];
         CSR_MAX_PACKET: cfg_max_packet = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic test_unsupported_version();
      // Reset values: version 0 reports unsupported with the count taken.
      send_byte(ACT_PROTECT, 8'hFF, 1'b0);
      send_byte(ACT_VALIDATE, 8'h00, 1'b1);
      send_byte(ACT_VALIDATE, 8'h7E, 1'b1);
   endtask

   task automatic test_crc_trailer();
      settle();
      write_reg(CSR_VERSION, {14'h3FFF, VER_CRC});
      send_byte(ACT_PROTECT, 8'h00, 1'b0);
      send_byte(ACT_PROTECT, 8'hFF, 1'b1);
      send_byte(ACT_PROTECT, 8'h5A, 1'b1);
   endtask

   task automatic test_validate_status();
      pkt_bytes.delete();
      append_trailer();
      send_packet(ACT_VALIDATE);
      send_byte(ACT_VALIDATE, 8'h12, 1'b0);
      send_byte(ACT_VALIDATE, 8'h34, 1'b1);
      send_byte(ACT_VALIDATE, 8'hDE, 1'b0);
      send_byte(ACT_VALIDATE, 8'hAD, 1'b0);
      send_byte(ACT_VALIDATE, 8'hBE, 1'b0);
      send_byte(ACT_VALIDATE, 8'hEF, 1'b1);
   endtask

   task automatic test_trailer_room();
      settle();
      write_reg(CSR_MAX_PACKET, 16'd0);
      send_byte(ACT_PROTECT, 8'h81, 1'b1);
      settle();
      write_reg(CSR_MAX_PACKET, 16'd6);
      send_byte(ACT_PROTECT, 8'h10, 1'b0);
      send_byte(ACT_PROTECT, 8'h20, 1'b1);
      send_byte(ACT_PROTECT, 8'h30, 1'b0);
      send_byte(ACT_PROTECT, 8'h40, 1'b0);
      send_byte(ACT_PROTECT, 8'h50, 1'b1);
      settle();
      write_reg(CSR_MAX_PACKET, 16'hFFFF);
   endtask

   task automatic test_plain_versions();
      settle();
      write_reg(CSR_VERSION, {14'h0000, VER_PLAIN_1});
      send_byte(ACT_PROTECT, 8'h00, 1'b0);
      send_byte(ACT_PROTECT, 8'hFF, 1'b1);
      send_byte(ACT_VALIDATE, 8'h0F, 1'b0);
      send_byte(ACT_VALIDATE, 8'hF0, 1'b1);
      settle();
      write_reg(CSR_VERSION, {14'h2AAA, VER_PLAIN_2});
      send_byte(ACT_PROTECT, 8'h3C, 1'b1);
      send_byte(ACT_VALIDATE, 8'hC3, 1'b1);
   endtask

   task automatic test_mixed_packet();
      settle();
      write_reg(CSR_VERSION, {14'h1555, VER_CRC});
      send_byte(ACT_VALIDATE, 8'h01, 1'b0);
      send_byte(ACT_VALIDATE, 8'h02, 1'b0);
      send_byte(ACT_VALIDATE, 8'h03, 1'b0);
      send_byte(ACT_VALIDATE, 8'h04, 1'b0);
      send_byte(ACT_VALIDATE, 8'h05, 1'b0);
      send_byte(ACT_PROTECT, 8'h06, 1'b0);
      send_byte(ACT_VALIDATE, 8'h07, 1'b1);
      // The version changes in the middle of a packet; the counters carry on.
      send_byte(ACT_PROTECT, 8'hAA, 1'b0);
      send_byte(ACT_PROTECT, 8'h55, 1'b0);
      settle();
      write_reg(CSR_VERSION, {14'h0000, VER_PLAIN_2});
      send_byte(ACT_VALIDATE, 8'h0F, 1'b1);
      settle();
      write_reg(CSR_VERSION, {14'h0000, VER_CRC});
   endtask

   task automatic test_spare_index();
      settle();
      write_reg(CSR_SPARE_2, 16'hFFFF);
      write_reg(CSR_SPARE_3, 16'h0000);
      send_byte(ACT_PROTECT, 8'h66, 1'b1);
   endtask

   task automatic test_backpressure();
      settle();
      gaps_on = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      make_body(24);
      send_packet(ACT_PROTECT);
      // The sender now waits for every result before going on.
      settle();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int          first;
      int          kind;
      int          pos;
      logic [1:0]  ver;
      logic [15:0] room;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         settle();
         ver = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 2)) : VER_CRC;
         case ($urandom_range(0, 4))
            0: room = 16'd0;
            1: room = 16'hFFFF;
            2: room = 16'($urandom);
            default: room = 16'($urandom_range(1, 20));
         endcase
         write_reg(CSR_VERSION, {14'($urandom), ver});
         write_reg(CSR_MAX_PACKET, room);
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(3, 8)) begin
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
               make_body($urandom_range(1, 12));
               send_packet(ACT_PROTECT);
            end else if (kind < 15) begin
               make_body($urandom_range(0, 8));
               append_trailer();
               send_packet(ACT_VALIDATE);
            end else if (kind < 17) begin
               make_body($urandom_range(0, 8));
               append_trailer();
               pos = $urandom_range(0, pkt_bytes.size() - 1);
               pkt_bytes[pos] = pkt_bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
               send_packet(ACT_VALIDATE);
            end else if (kind < 18) begin
               make_body($urandom_range(1, 3));
               send_packet(ACT_VALIDATE);
            end else begin
               make_body($urandom_range(1, 10));
               foreach (pkt_bytes[i])
                  send_byte(1'($urandom_range(0, 1)), pkt_bytes[i], i == pkt_bytes.size() - 1);
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   // Result side: a random stall after each transfer with gaps on, or a long hold on request.
   initial begin : rsp_sink
      int stall;
      while (reset) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (rsp_valid && rsp_ready && gaps_on) begin
            stall = $urandom_range(0, 5);
         end else begin
            stall = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending.size() == 0) begin
            $error("unexpected result: out_byte %0h out_last %0d status %0d body_length %0d",
                   rsp_out_byte, rsp_out_last, rsp_status, rsp_body_length);
            mismatches++;
         end else begin
            want = pending.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_out_last !== want.out_last) begin
               $error("out_last: expected %0d, got %0d", want.out_last, rsp_out_last);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_body_length !== want.body_length) begin
               $error("body_length: expected %0d, got %0d", want.body_length, rsp_body_length);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $error("no transfer for %0d cycles, %0d results outstanding", QUIET_LIMIT,
             pending.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unsupported_version();
      test_crc_trailer();
      test_validate_status();
      test_trailer_room();
      test_plain_versions();
      test_mixed_packet();
      test_spare_index();
      test_backpressure();
      test_random_traffic();
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
design/ctf_pkg.sv
design/ctf_burst.sv
design/crc32_trailer_framer.sv
bench/crc32_trailer_framer_tb.sv
